// ===== hw/rtl/scancode_set1_translator_assert.svh =====
// Assertion macros used by the scan code translator checker.
// Each macro takes a label, a condition sampled at the edge and a
// consequence, and reports a failure by $error.
`ifndef SCANCODE_SET1_TRANSLATOR_ASSERT_SVH
`define SCANCODE_SET1_TRANSLATOR_ASSERT_SVH

// Consequence must hold at the same edge.
`define SCS1_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scs1 check failed: same-cycle rule");

// Consequence must hold at the following edge.
`define SCS1_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scs1 check failed: next-cycle rule");

`endif

// ===== hw/rtl/scs1_pkg.sv =====
`timescale 1ns / 1ps

package scs1_pkg;

	// Result of translating one byte.
	typedef struct packed {
		logic [8:0] key;
		logic [7:0] mods;
		logic       prefix;
	} xlat_t;

	// Key codes
	localparam logic [8:0] KEY_NONE   = 9'd0;
	localparam logic [8:0] KEY_ESC    = 9'd256;
	localparam logic [8:0] KEY_F1     = 9'd257;
	localparam logic [8:0] KEY_F11    = 9'd267;
	localparam logic [8:0] KEY_F12    = 9'd268;
	localparam logic [8:0] KEY_CAPS   = 9'd269;
	localparam logic [8:0] KEY_NUM    = 9'd270;
	localparam logic [8:0] KEY_SCROLL = 9'd271;
	localparam logic [8:0] KEY_HOME   = 9'd272;
	localparam logic [8:0] KEY_UP     = 9'd273;
	localparam logic [8:0] KEY_PGUP   = 9'd274;
	localparam logic [8:0] KEY_LEFT   = 9'd275;
	localparam logic [8:0] KEY_RIGHT  = 9'd276;
	localparam logic [8:0] KEY_END    = 9'd277;
	localparam logic [8:0] KEY_DOWN   = 9'd278;
	localparam logic [8:0] KEY_PGDN   = 9'd279;
	localparam logic [8:0] KEY_INS    = 9'd280;
	localparam logic [8:0] KEY_DEL    = 9'd281;
	localparam logic [8:0] KEY_MAX    = KEY_DEL;

	// Modifier bit positions
	localparam int MB_LSHIFT = 0;
	localparam int MB_RSHIFT = 1;
	localparam int MB_LCTRL  = 2;
	localparam int MB_RCTRL  = 3;
	localparam int MB_LALT   = 4;
	localparam int MB_RALT   = 5;
	localparam int MB_CAPS   = 6;
	localparam int MB_NUM    = 7;

	// Scan codes
	localparam logic [7:0] SC_PREFIX = 8'hE0;
	localparam logic [6:0] SC_ESC    = 7'h01;
	localparam logic [6:0] SC_CTRL   = 7'h1D;
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_ALT    = 7'h38;
	localparam logic [6:0] SC_CAPS   = 7'h3A;
	localparam logic [6:0] SC_F1     = 7'h3B;
	localparam logic [6:0] SC_F10    = 7'h44;
	localparam logic [6:0] SC_NUM    = 7'h45;
	localparam logic [6:0] SC_SCROLL = 7'h46;
	localparam logic [6:0] SC_HOME   = 7'h47;
	localparam logic [6:0] SC_UP     = 7'h48;
	localparam logic [6:0] SC_PGUP   = 7'h49;
	localparam logic [6:0] SC_LEFT   = 7'h4B;
	localparam logic [6:0] SC_RIGHT  = 7'h4D;
	localparam logic [6:0] SC_END    = 7'h4F;
	localparam logic [6:0] SC_DOWN   = 7'h50;
	localparam logic [6:0] SC_PGDN   = 7'h51;
	localparam logic [6:0] SC_INS    = 7'h52;
	localparam logic [6:0] SC_DEL    = 7'h53;
	localparam logic [6:0] SC_F11    = 7'h57;
	localparam logic [6:0] SC_F12    = 7'h58;
	localparam logic [6:0] ROM_DEPTH = 7'h59;

	// Unshifted character table
	function automatic logic [7:0] rom_plain(input logic [6:0] sc);
		logic [7:0] ch;
		unique case (sc)
			7'h02: ch = "1";
			7'h03: ch = "2";
			7'h04: ch = "3";
			7'h05: ch = "4";
			7'h06: ch = "5";
			7'h07: ch = "6";
			7'h08: ch = "7";
			7'h09: ch = "8";
			7'h0A: ch = "9";
			7'h0B: ch = "0";
			7'h0C: ch = "-";
			7'h0D: ch = "=";
			7'h0E: ch = 8'h08;
			7'h0F: ch = 8'h09;
			7'h10: ch = "q";
			7'h11: ch = "w";
			7'h12: ch = "e";
			7'h13: ch = "r";
			7'h14: ch = "t";
			7'h15: ch = "y";
			7'h16: ch = "u";
			7'h17: ch = "i";
			7'h18: ch = "o";
			7'h19: ch = "p";
			7'h1A: ch = "[";
			7'h1B: ch = "]";
			7'h1C: ch = 8'h0A;
			7'h1E: ch = "a";
			7'h1F: ch = "s";
			7'h20: ch = "d";
			7'h21: ch = "f";
			7'h22: ch = "g";
			7'h23: ch = "h";
			7'h24: ch = "j";
			7'h25: ch = "k";
			7'h26: ch = "l";
			7'h27: ch = ";";
			7'h28: ch = 8'h27;
			7'h29: ch = 8'h60;
			7'h2B: ch = 8'h5C;
			7'h2C: ch = "z";
			7'h2D: ch = "x";
			7'h2E: ch = "c";
			7'h2F: ch = "v";
			7'h30: ch = "b";
			7'h31: ch = "n";
			7'h32: ch = "m";
			7'h33: ch = ",";
			7'h34: ch = ".";
			7'h35: ch = "/";
			7'h37: ch = "*";
			7'h39: ch = " ";
			7'h47: ch = "7";
			7'h48: ch = "8";
			7'h49: ch = "9";
			7'h4A: ch = "-";
			7'h4B: ch = "4";
			7'h4C: ch = "5";
			7'h4D: ch = "6";
			7'h4E: ch = "+";
			7'h4F: ch = "1";
			7'h50: ch = "2";
			7'h51: ch = "3";
			7'h52: ch = "0";
			7'h53: ch = ".";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Shifted character table
	function automatic logic [7:0] rom_shift(input logic [6:0] sc);
		logic [7:0] ch;
		unique case (sc)
			7'h02: ch = "!";
			7'h03: ch = "@";
			7'h04: ch = "#";
			7'h05: ch = "$";
			7'h06: ch = "%";
			7'h07: ch = "^";
			7'h08: ch = "&";
			7'h09: ch = "*";
			7'h0A: ch = "(";
			7'h0B: ch = ")";
			7'h0C: ch = "_";
			7'h0D: ch = "+";
			7'h0E: ch = 8'h08;
			7'h0F: ch = 8'h09;
			7'h10: ch = "Q";
			7'h11: ch = "W";
			7'h12: ch = "E";
			7'h13: ch = "R";
			7'h14: ch = "T";
			7'h15: ch = "Y";
			7'h16: ch = "U";
			7'h17: ch = "I";
			7'h18: ch = "O";
			7'h19: ch = "P";
			7'h1A: ch = "{";
			7'h1B: ch = "}";
			7'h1C: ch = 8'h0A;
			7'h1E: ch = "A";
			7'h1F: ch = "S";
			7'h20: ch = "D";
			7'h21: ch = "F";
			7'h22: ch = "G";
			7'h23: ch = "H";
			7'h24: ch = "J";
			7'h25: ch = "K";
			7'h26: ch = "L";
			7'h27: ch = ":";
			7'h28: ch = 8'h22;
			7'h29: ch = "~";
			7'h2B: ch = "|";
			7'h2C: ch = "Z";
			7'h2D: ch = "X";
			7'h2E: ch = "C";
			7'h2F: ch = "V";
			7'h30: ch = "B";
			7'h31: ch = "N";
			7'h32: ch = "M";
			7'h33: ch = "<";
			7'h34: ch = ">";
			7'h35: ch = "?";
			7'h37: ch = "*";
			7'h39: ch = " ";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Translate one byte against the current modifiers and prefix flag.
	function automatic xlat_t translate(input logic [7:0] raw, input logic [7:0] mods,
			input logic pend);
		xlat_t      r;
		logic [6:0] sc;
		logic [7:0] ch;
		r.mods   = mods;
		r.prefix = 1'b0;
		r.key    = KEY_NONE;
		sc       = raw[6:0];
		ch       = 8'h00;
		if (pend) begin
			// Extended code; a second prefix reads as a release and drops out
			if (raw[7]) begin
				if (sc == SC_CTRL) r.mods[MB_RCTRL] = 1'b0;
				if (sc == SC_ALT)  r.mods[MB_RALT]  = 1'b0;
			end else begin
				unique case (sc)
					SC_CTRL:  r.mods[MB_RCTRL] = 1'b1;
					SC_ALT:   r.mods[MB_RALT]  = 1'b1;
					SC_HOME:  r.key = KEY_HOME;
					SC_UP:    r.key = KEY_UP;
					SC_PGUP:  r.key = KEY_PGUP;
					SC_LEFT:  r.key = KEY_LEFT;
					SC_RIGHT: r.key = KEY_RIGHT;
					SC_END:   r.key = KEY_END;
					SC_DOWN:  r.key = KEY_DOWN;
					SC_PGDN:  r.key = KEY_PGDN;
					SC_INS:   r.key = KEY_INS;
					SC_DEL:   r.key = KEY_DEL;
					default:  r.key = KEY_NONE;
				endcase
			end
		end else if (raw == SC_PREFIX) begin
			r.prefix = 1'b1;
		end else if (raw[7]) begin
			// Plain release clears both shifts and the left ctrl and alt
			unique case (sc)
				SC_LSHIFT: r.mods[MB_LSHIFT] = 1'b0;
				SC_RSHIFT: r.mods[MB_RSHIFT] = 1'b0;
				SC_CTRL:   r.mods[MB_LCTRL]  = 1'b0;
				SC_ALT:    r.mods[MB_LALT]   = 1'b0;
				default:   r.key = KEY_NONE;
			endcase
		end else begin
			priority if (sc == SC_LSHIFT) begin
				r.mods[MB_LSHIFT] = 1'b1;
			end else if (sc == SC_RSHIFT) begin
				r.mods[MB_RSHIFT] = 1'b1;
			end else if (sc == SC_CTRL) begin
				r.mods[MB_LCTRL] = 1'b1;
			end else if (sc == SC_ALT) begin
				r.mods[MB_LALT] = 1'b1;
			end else if (sc == SC_CAPS) begin
				r.mods[MB_CAPS] = ~mods[MB_CAPS];
				r.key = KEY_CAPS;
			end else if (sc == SC_NUM) begin
				r.mods[MB_NUM] = ~mods[MB_NUM];
				r.key = KEY_NUM;
			end else if (sc == SC_SCROLL) begin
				r.key = KEY_SCROLL;
			end else if (sc == SC_ESC) begin
				r.key = KEY_ESC;
			end else if (sc == SC_F11) begin
				r.key = KEY_F11;
			end else if (sc == SC_F12) begin
				r.key = KEY_F12;
			end else if (sc >= SC_F1 && sc <= SC_F10) begin
				r.key = KEY_F1 + {2'b00, sc - SC_F1};
			end else if (sc >= ROM_DEPTH) begin
				r.key = KEY_NONE;
			end else begin
				// Look up, swap case under caps, fold under ctrl
				ch = (mods[MB_LSHIFT] || mods[MB_RSHIFT]) ? rom_shift(sc) : rom_plain(sc);
				if (mods[MB_CAPS]) begin
					if (ch >= "a" && ch <= "z")      ch = ch - 8'h20;
					else if (ch >= "A" && ch <= "Z") ch = ch + 8'h20;
				end
				if (mods[MB_LCTRL] || mods[MB_RCTRL]) begin
					if ((ch >= "@" && ch <= "_") || (ch >= "a" && ch <= "z"))
						ch = {3'b000, ch[4:0]};
				end
				r.key = {1'b0, ch};
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/scancode_set1_translator.sv =====
`timescale 1ns / 1ps

// Scan code set 1 translator.
// Input channel: one raw keyboard byte per beat on raw_byte, qualified by
// in_valid and held off by in_stall. Output channel: one beat per input
// byte on key_code and modifier_bits, qualified by out_valid and held off
// by out_stall. Every input byte gives exactly one output beat; key_code 0
// means no key (prefix bytes, releases, modifier makes, unmapped codes).
// modifier_bits shows the modifiers after the byte is handled.
// A byte passes through an input register, then the translation logic,
// then the result register.
// Throughput: one byte per cycle while the receiver does not stall the
// output; the modifier and prefix registers update once per byte.
// Reset clears the modifiers, the pending prefix and both valid stages.
// When the receiver stalls, the result is held and one more byte can wait
// in the input register; in_stall then rises until the output is taken.
module scancode_set1_translator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] raw_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [8:0] key_code,
	output logic [7:0] modifier_bits
);

	logic               valid_s1;
	logic [7:0]         raw_s1;
	logic               valid_s2;
	logic [8:0]         key_s2;
	logic [7:0]         mods_s2;
	logic [7:0]         mods_q;
	logic               prefix_q;
	logic               adv;
	logic               take;
	scs1_pkg::xlat_t    xl;

	// Advance stage 1 into the result register when that is free or drained
	assign adv      = ~valid_s2 | ~out_stall;
	assign in_stall = valid_s1 & ~adv;
	assign take     = in_valid & ~in_stall;

	// Translate the held byte
	always_comb begin
		xl = scs1_pkg::translate(raw_s1, mods_q, prefix_q);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mods_q   <= '0;
			prefix_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (adv && valid_s1) begin
				mods_q   <= xl.mods;
				prefix_q <= xl.prefix;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take) raw_s1 <= raw_byte;
		if (adv && valid_s1) begin
			key_s2  <= xl.key;
			mods_s2 <= xl.mods;
		end
	end

	assign out_valid     = valid_s2;
	assign key_code      = key_s2;
	assign modifier_bits = mods_s2;

endmodule

// ===== hw/rtl/scs1_checker.sv =====
`timescale 1ns / 1ps

`include "scancode_set1_translator_assert.svh"

module scs1_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] raw_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [8:0] key_code,
	input logic [7:0] modifier_bits
);

	logic ctrl_held;

	assign ctrl_held = modifier_bits[scs1_pkg::MB_LCTRL] | modifier_bits[scs1_pkg::MB_RCTRL];

	// Hold a stalled result beat
	`SCS1_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(key_code) && $stable(modifier_bits))

	// Hold a stalled input beat
	`SCS1_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(raw_byte))

	// Keep key codes inside the defined range
	`SCS1_ASSERT_SAME(a_key_range, out_valid, key_code <= scs1_pkg::KEY_MAX)

	// With ctrl held, no letter or @.._ character survives folding
	`SCS1_ASSERT_SAME(a_ctrl_fold, out_valid && ctrl_held && !key_code[8],
		!((key_code[7:0] >= 8'h40 && key_code[7:0] <= 8'h5F) ||
		  (key_code[7:0] >= 8'h61 && key_code[7:0] <= 8'h7A)))

	// An empty output register never backs up the input
	`SCS1_ASSERT_SAME(a_no_stall_empty, !out_valid, !in_stall)

endmodule

bind scancode_set1_translator scs1_checker u_scs1_checker (.*);

// ===== test/scancode_set1_translator_tb.sv =====
`timescale 1ns / 1ps

module testbench;

	// Character maps indexed by make code, unshifted and shifted
	localparam logic [7:0] UNSHIFTED_MAP [0:88] = '{
		'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h08, 'h09,
		'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69, 'h6F, 'h70, 'h5B, 'h5D, 'h0A, 'h00, 'h61, 'h73,
		'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B, 'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76,
		'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
		'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37, 'h38, 'h39, 'h2D, 'h34, 'h35, 'h36, 'h2B, 'h31,
		'h32, 'h33, 'h30, 'h2E, 'h00, 'h00, 'h00, 'h00, 'h00
	};
	localparam logic [7:0] SHIFTED_MAP [0:88] = '{
		'h00, 'h00, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5E, 'h26, 'h2A, 'h28, 'h29, 'h5F, 'h2B, 'h08, 'h09,
		'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49, 'h4F, 'h50, 'h7B, 'h7D, 'h0A, 'h00, 'h41, 'h53,
		'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h3A, 'h22, 'h7E, 'h00, 'h7C, 'h5A, 'h58, 'h43, 'h56,
		'h42, 'h4E, 'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h2A, 'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
		'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
		'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00
	};

	// Opening keystrokes: extremes, shifted and caps letters, ctrl folding,
	// lock keys, function keys, out-of-map codes and extended pairs
	localparam int OPENING_LEN = 33;
	localparam logic [7:0] OPENING_BYTES [0:OPENING_LEN-1] = '{
		'h00, 'hFF, 'h1E, 'h2A, 'h1E, 'h47, 'h3A, 'h1E, 'h1D, 'h1E, 'h03,
		'hAA, 'h9D, 'h3A, 'h45, 'h46, 'h01, 'h3B, 'h57, 'h58, 'h59,
		'hE0, 'h48, 'hE0, 'hE0, 'hE0, 'h1D, 'hE0, 'h9D, 'hE0, 'h38, 'hE0, 'h00
	};

	typedef struct packed {
		logic [8:0] key;
		logic [7:0] mods;
	} key_beat_t;

	// Keyboard state tracker and queue of expected output beats
	class keystroke_scoreboard;
		logic [7:0] held_mods;
		bit         ext_armed;
		key_beat_t  expected_q[$];
		int         mismatches;
		int         beats_checked;
		int         keys_seen;
		int         ext_pairs;

		function new();
			held_mods  = '0;
			ext_armed  = 1'b0;
			mismatches = 0;
			beats_checked = 0;
			keys_seen  = 0;
			ext_pairs  = 0;
		endfunction

		// Map a printable make code through shift, caps and ctrl
		function logic [8:0] char_key(logic [6:0] sc);
			logic [7:0] ch;
			ch = (held_mods[scs1_pkg::MB_LSHIFT] | held_mods[scs1_pkg::MB_RSHIFT]) ?
				SHIFTED_MAP[sc] : UNSHIFTED_MAP[sc];
			if (held_mods[scs1_pkg::MB_CAPS]) begin
				if (ch >= 8'h61 && ch <= 8'h7A)
					ch = ch - 8'h20;
				else if (ch >= 8'h41 && ch <= 8'h5A)
					ch = ch + 8'h20;
			end
			if (held_mods[scs1_pkg::MB_LCTRL] | held_mods[scs1_pkg::MB_RCTRL]) begin
				if (ch >= 8'h40 && ch <= 8'h5F)
					ch = ch & 8'h1F;
				else if (ch >= 8'h61 && ch <= 8'h7A)
					ch = ch - 8'h60;
			end
			return {1'b0, ch};
		endfunction

		// Advance the tracked state by one accepted byte and queue its beat
		function void note_byte(logic [7:0] raw);
			key_beat_t  beat;
			logic [6:0] sc;
			sc = raw[6:0];
			beat.key = scs1_pkg::KEY_NONE;
			if (ext_armed) begin
				ext_armed = 1'b0;
				ext_pairs++;
				if (raw[7]) begin
					if (sc == scs1_pkg::SC_CTRL) held_mods[scs1_pkg::MB_RCTRL] = 1'b0;
					if (sc == scs1_pkg::SC_ALT) held_mods[scs1_pkg::MB_RALT] = 1'b0;
				end else begin
					case (sc)
						scs1_pkg::SC_CTRL:  held_mods[scs1_pkg::MB_RCTRL] = 1'b1;
						scs1_pkg::SC_ALT:   held_mods[scs1_pkg::MB_RALT] = 1'b1;
						scs1_pkg::SC_HOME:  beat.key = scs1_pkg::KEY_HOME;
						scs1_pkg::SC_UP:    beat.key = scs1_pkg::KEY_UP;
						scs1_pkg::SC_PGUP:  beat.key = scs1_pkg::KEY_PGUP;
						scs1_pkg::SC_LEFT:  beat.key = scs1_pkg::KEY_LEFT;
						scs1_pkg::SC_RIGHT: beat.key = scs1_pkg::KEY_RIGHT;
						scs1_pkg::SC_END:   beat.key = scs1_pkg::KEY_END;
						scs1_pkg::SC_DOWN:  beat.key = scs1_pkg::KEY_DOWN;
						scs1_pkg::SC_PGDN:  beat.key = scs1_pkg::KEY_PGDN;
						scs1_pkg::SC_INS:   beat.key = scs1_pkg::KEY_INS;
						scs1_pkg::SC_DEL:   beat.key = scs1_pkg::KEY_DEL;
						default:            beat.key = scs1_pkg::KEY_NONE;
					endcase
				end
			end else if (raw == scs1_pkg::SC_PREFIX) begin
				ext_armed = 1'b1;
			end else if (raw[7]) begin
				case (sc)
					scs1_pkg::SC_LSHIFT: held_mods[scs1_pkg::MB_LSHIFT] = 1'b0;
					scs1_pkg::SC_RSHIFT: held_mods[scs1_pkg::MB_RSHIFT] = 1'b0;
					scs1_pkg::SC_CTRL:   held_mods[scs1_pkg::MB_LCTRL] = 1'b0;
					scs1_pkg::SC_ALT:    held_mods[scs1_pkg::MB_LALT] = 1'b0;
					default:             beat.key = scs1_pkg::KEY_NONE;
				endcase
			end else begin
				case (sc)
					scs1_pkg::SC_LSHIFT: held_mods[scs1_pkg::MB_LSHIFT] = 1'b1;
					scs1_pkg::SC_RSHIFT: held_mods[scs1_pkg::MB_RSHIFT] = 1'b1;
					scs1_pkg::SC_CTRL:   held_mods[scs1_pkg::MB_LCTRL] = 1'b1;
					scs1_pkg::SC_ALT:    held_mods[scs1_pkg::MB_LALT] = 1'b1;
					scs1_pkg::SC_CAPS: begin
						held_mods[scs1_pkg::MB_CAPS] = ~held_mods[scs1_pkg::MB_CAPS];
						beat.key = scs1_pkg::KEY_CAPS;
					end
					scs1_pkg::SC_NUM: begin
						held_mods[scs1_pkg::MB_NUM] = ~held_mods[scs1_pkg::MB_NUM];
						beat.key = scs1_pkg::KEY_NUM;
					end
					scs1_pkg::SC_SCROLL: beat.key = scs1_pkg::KEY_SCROLL;
					scs1_pkg::SC_ESC:    beat.key = scs1_pkg::KEY_ESC;
					scs1_pkg::SC_F11:    beat.key = scs1_pkg::KEY_F11;
					scs1_pkg::SC_F12:    beat.key = scs1_pkg::KEY_F12;
					default: begin
						if (sc >= scs1_pkg::SC_F1 && sc <= scs1_pkg::SC_F10)
							beat.key = scs1_pkg::KEY_F1 + 9'(sc - scs1_pkg::SC_F1);
						else if (sc < scs1_pkg::ROM_DEPTH)
							beat.key = char_key(sc);
					end
				endcase
			end
			beat.mods = held_mods;
			expected_q.push_back(beat);
		endfunction

		// Compare one output beat with the oldest expectation
		function void check_beat(logic [8:0] key, logic [7:0] mods);
			key_beat_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected output beat: key_code %0d modifier_bits %02h", key, mods);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			beats_checked++;
			if (want.key != scs1_pkg::KEY_NONE) keys_seen++;
			if (key !== want.key) begin
				$error("key_code: expected %0d, actual %0d", want.key, key);
				mismatches++;
			end
			if (mods !== want.mods) begin
				$error("modifier_bits: expected %02h, actual %02h", want.mods, mods);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] raw_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [8:0] key_code;
	logic [7:0] modifier_bits;

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_left = 0;
	int bytes_sent = 0;

	keystroke_scoreboard tracker = new();

	scancode_set1_translator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_byte     (raw_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_code     (key_code),
		.modifier_bits(modifier_bits)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stall the output at random, or hold it off for a counted stretch
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
		end
	end

	// Check every output beat taken
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_beat(key_code, modifier_bits);
	end

	// Offer one byte, with random gaps first, and wait for the beat to go in
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_byte(b);
		bytes_sent++;
	endtask

	// Stop offering and wait until every expected beat has come out
	task automatic drain_output();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// One random keystroke: mostly plausible make, break and extended codes
	task automatic type_random_stroke();
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			send_byte(8'($urandom_range(0, 127)));
		end else if (pick < 50) begin
			send_byte(8'($urandom_range(128, 255)));
		end else if (pick < 68) begin
			case ($urandom_range(0, 3))
				0: b = {1'b0, scs1_pkg::SC_LSHIFT};
				1: b = {1'b0, scs1_pkg::SC_RSHIFT};
				2: b = {1'b0, scs1_pkg::SC_CTRL};
				default: b = {1'b0, scs1_pkg::SC_ALT};
			endcase
			b[7] = 1'($urandom_range(0, 1));
			send_byte(b);
		end else if (pick < 85) begin
			send_byte(scs1_pkg::SC_PREFIX);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				case ($urandom_range(0, 9))
					0: b = {1'b0, scs1_pkg::SC_HOME};
					1: b = {1'b0, scs1_pkg::SC_UP};
					2: b = {1'b0, scs1_pkg::SC_PGUP};
					3: b = {1'b0, scs1_pkg::SC_LEFT};
					4: b = {1'b0, scs1_pkg::SC_RIGHT};
					5: b = {1'b0, scs1_pkg::SC_END};
					6: b = {1'b0, scs1_pkg::SC_DOWN};
					7: b = {1'b0, scs1_pkg::SC_PGDN};
					8: b = {1'b0, scs1_pkg::SC_INS};
					default: b = {1'b0, scs1_pkg::SC_DEL};
				endcase
			end else if (pick < 75) begin
				b = ($urandom_range(0, 1) != 0) ? {1'b0, scs1_pkg::SC_CTRL} :
					{1'b0, scs1_pkg::SC_ALT};
				b[7] = 1'($urandom_range(0, 1));
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_byte(b);
		end else if (pick < 92) begin
			send_byte(($urandom_range(0, 1) != 0) ? {1'b0, scs1_pkg::SC_CAPS} :
				{1'b0, scs1_pkg::SC_NUM});
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int guard;

		// Hold reset, then release it
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily
		send_gap_pct = 26;
		recv_gap_pct = 66;
		for (int i = 0; i < OPENING_LEN; i++)
			send_byte(OPENING_BYTES[i]);
		drain_output();

		// Hold the output off while bytes keep coming, so the input backs up
		hold_left = 60;
		repeat (30) type_random_stroke();
		while (bytes_sent < 450) type_random_stroke();
		drain_output();

		// Sender idles heavily, receiver lightly
		send_gap_pct = 66;
		recv_gap_pct = 26;
		while (bytes_sent < 880) type_random_stroke();
		drain_output();

		// No idling on either side, then one more long hold
		send_gap_pct = 0;
		recv_gap_pct = 0;
		while (bytes_sent < 1100) type_random_stroke();
		hold_left = 40;
		while (bytes_sent < 1320) type_random_stroke();

		// Wait out the last beats, then let the pipeline settle
		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (tracker.pending() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d expected beats never came out", tracker.pending());
			tracker.mismatches += tracker.pending();
		end

		$display("Sent %0d scan bytes (%0d extended pairs); checked %0d beats, %0d with a key.",
			bytes_sent, tracker.ext_pairs, tracker.beats_checked, tracker.keys_seen);
		$display("Profiles: light/heavy, heavy/light and no idling, with two long output holds.");
		if (tracker.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== scancode_set1_translator.f =====
+incdir+hw/rtl
hw/rtl/scs1_pkg.sv
hw/rtl/scancode_set1_translator.sv
hw/rtl/scs1_checker.sv
test/scancode_set1_translator_tb.sv
